FILE: rtl/core/kcl_pkg.sv
// kcl_pkg: shared types and constants of the keypad code lock
// key codes, result codes, register indexes, state and result records
// no dependencies
`timescale 1ns / 1ps

package kcl_pkg;

  // code length range and default
  localparam int MAX_CODE_LENGTH = 16;
  localparam int CODE_LENGTH_DEF = 6;

  // field widths
  localparam int DIGIT_W   = 4;
  localparam int CODE_W    = 24;
  localparam int ERR_W     = 4;
  localparam int WAIT_W    = 7;
  localparam int EV_W      = 3;
  localparam int HELD_W    = 3;
  localparam int KEY_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;
  localparam int S_DATA_W  = 8;
  localparam int M_DATA_W  = 24;

  // reset values of the registers
  localparam logic [CODE_W-1:0] CODE_DIGITS_RST  = 24'h123456;
  localparam logic [ERR_W-1:0]  MAX_ERRORS_RST   = 4'd3;
  localparam logic [WAIT_W-1:0] INITIAL_WAIT_RST = 7'd2;
  localparam logic [WAIT_W-1:0] WAIT_CAP_RST     = 7'd99;
  localparam logic [ERR_W-1:0]  ERR_SAT          = 4'd15;

  // key codes
  localparam logic [KEY_W-1:0] KEY_DIGIT_LO = 4'd1;
  localparam logic [KEY_W-1:0] KEY_DIGIT_HI = 4'd9;
  localparam logic [KEY_W-1:0] KEY_CONFIRM  = 4'd10;
  localparam logic [KEY_W-1:0] KEY_DELETE   = 4'd11;

  // item kinds
  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [EV_W-1:0] {
    EV_IGNORED  = 3'd0,
    EV_STORED   = 3'd1,
    EV_REMOVED  = 3'd2,
    EV_ACCEPT   = 3'd3,
    EV_REJECT   = 3'd4,
    EV_LOCKED   = 3'd5,
    EV_TICK     = 3'd6,
    EV_RELEASED = 3'd7
  } ev_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CODE_DIGITS  = 2'd0,
    CFG_MAX_ERRORS   = 2'd1,
    CFG_INITIAL_WAIT = 2'd2,
    CFG_WAIT_CAP     = 2'd3
  } cfg_idx_t;

  // configuration seen by the step logic
  typedef struct packed {
    logic [CODE_W-1:0] code_digits;
    logic [ERR_W-1:0]  max_errors;
    logic [WAIT_W-1:0] wait_cap;
  } cfg_t;

  // lockout state
  typedef struct packed {
    logic [ERR_W-1:0]  error_tally;
    logic              lock_flag;
    logic [WAIT_W-1:0] countdown;
    logic [WAIT_W-1:0] next_wait;
  } lock_state_t;

  // result item, event in the lowest bits
  typedef struct packed {
    logic [WAIT_W-1:0] seconds_left;
    logic              locked;
    logic [ERR_W-1:0]  failures;
    logic [HELD_W-1:0] digits_held;
    ev_t               event_res;
  } result_t;

  localparam int RES_W = $bits(result_t);

endpackage

FILE: rtl/core/keypad_code_lock_with_lockout_core.sv
// keypad_code_lock_with_lockout_core: top level of the keypad code lock
// input register, step logic, state, configuration and result register
// depends on kcl_pkg and kcl_step
`timescale 1ns / 1ps

// Keypad code lock with escalating lockout. Each input item is either a
// key press (tuser = 0, key code in tdata) or a one-second tick (tuser = 1).
// Digits 1-9 build up an entry of CODE_LENGTH digits; the digit that fills
// the entry triggers the compare against code_digits, confirm (10) checks at
// once and so always fails on a short entry, delete (11) drops the last
// digit, every other code is ignored. Every item gives exactly one result
// item carrying the event and the state after it. Failures count up to 15;
// reaching max_errors locks the keypad for the current wait and doubles the
// next wait up to wait_cap, and only a write of initial_wait brings it back.
// While locked, keys are ignored and ticks count down; the release clears
// the failure count. Rate: one item per clock while m_tready keeps up; the
// accepting edge loads the input register, and the state update then loads
// the result register from the input register. While a result waits for
// m_tready the input register still takes one more item.
// Configuration writes are meant for an idle block only.

module keypad_code_lock_with_lockout_core #(
  parameter int CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input item stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [kcl_pkg::S_DATA_W-1:0]  s_tdata,   // [3:0] key_code, [7:4] zero
  input  logic                          s_tuser,   // [0] kind
  // result item stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [kcl_pkg::M_DATA_W-1:0]  m_tdata,   // [2:0] event_res, [5:3] digits_held,
                                                   // [9:6] failures, [10] locked,
                                                   // [17:11] seconds_left, [23:18] zero
  // configuration write port
  input  logic                          cfg_we,
  input  logic [kcl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kcl_pkg::CFG_W-1:0]     cfg_data
);
  import kcl_pkg::*;

  localparam int CNT_W = $clog2(CODE_LENGTH + 1);

  // input register
  logic               in_valid;
  logic               in_kind;
  logic [KEY_W-1:0]   in_key;

  // configuration
  cfg_t               cfg;

  // state
  lock_state_t        st;
  logic [CNT_W-1:0]   count;
  logic [DIGIT_W-1:0] entered_digits [CODE_LENGTH];

  // step results
  lock_state_t        st_next;
  logic [CNT_W-1:0]   count_next;
  logic               push;
  ev_t                ev;

  // result register
  logic               out_valid;
  result_t            out_res;
  result_t            res_next;

  logic               advance;

  // the result register frees when it is empty or being read
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = M_DATA_W'(out_res);

  kcl_step #(
    .CODE_LENGTH (CODE_LENGTH),
    .CNT_W       (CNT_W)
  ) u_step (
    .kind       (in_kind),
    .key_code   (in_key),
    .cfg        (cfg),
    .st         (st),
    .count      (count),
    .digits     (entered_digits),
    .st_next    (st_next),
    .count_next (count_next),
    .push       (push),
    .ev         (ev)
  );

  always_comb begin
    res_next.event_res    = ev;
    res_next.digits_held  = HELD_W'(count_next);
    res_next.failures     = st_next.error_tally;
    res_next.locked       = st_next.lock_flag;
    res_next.seconds_left = st_next.lock_flag ? st_next.countdown : '0;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_kind <= s_tuser;
      in_key  <= s_tdata[KEY_W-1:0];
    end
  end

  // state update and configuration; a write of initial_wait reloads the wait
  always_ff @(posedge clk) begin
    if (rst) begin
      count           <= '0;
      st.error_tally  <= '0;
      st.lock_flag    <= 1'b0;
      st.countdown    <= '0;
      st.next_wait    <= INITIAL_WAIT_RST;
      cfg.code_digits <= CODE_DIGITS_RST;
      cfg.max_errors  <= MAX_ERRORS_RST;
      cfg.wait_cap    <= WAIT_CAP_RST;
    end else begin
      if (in_valid && advance) begin
        st    <= st_next;
        count <= count_next;
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CODE_DIGITS:  cfg.code_digits <= cfg_data[CODE_W-1:0];
          CFG_MAX_ERRORS:   cfg.max_errors  <= cfg_data[ERR_W-1:0];
          CFG_INITIAL_WAIT: st.next_wait    <= cfg_data[WAIT_W-1:0];
          CFG_WAIT_CAP:     cfg.wait_cap    <= cfg_data[WAIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // digit store: only slots below the count are ever read
  always_ff @(posedge clk) begin
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (in_valid && advance && push && (count == CNT_W'(i))) begin
        entered_digits[i] <= in_key;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (advance && in_valid) begin
      out_res <= res_next;
    end
  end

endmodule

FILE: rtl/core/kcl_step.sv
// kcl_step: next-state logic of the code lock for one item
// digit entry, code compare, failure count and lockout countdown
// depends on kcl_pkg
`timescale 1ns / 1ps

module kcl_step #(
  parameter int CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF,
  parameter int CNT_W       = $clog2(CODE_LENGTH + 1)
) (
  input  logic                      kind,
  input  logic [kcl_pkg::KEY_W-1:0] key_code,
  input  kcl_pkg::cfg_t             cfg,
  input  kcl_pkg::lock_state_t      st,
  input  logic [CNT_W-1:0]          count,
  input  logic [kcl_pkg::DIGIT_W-1:0] digits [CODE_LENGTH],
  output kcl_pkg::lock_state_t      st_next,
  output logic [CNT_W-1:0]          count_next,
  output logic                      push,
  output kcl_pkg::ev_t              ev
);
  import kcl_pkg::*;

  localparam int EXT_W = DIGIT_W * MAX_CODE_LENGTH;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CODE_LENGTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CODE_LENGTH);

  logic [EXT_W-1:0]   code_ext;
  logic               match;
  logic [DIGIT_W-1:0] dig;
  logic               is_digit;
  logic               do_check;
  logic               ok;
  logic [ERR_W-1:0]   tally_inc;
  logic [WAIT_W:0]    doubled;
  logic [WAIT_W-1:0]  cd_dec;

  assign code_ext = EXT_W'(cfg.code_digits);

  // entry with the incoming digit in the slot it would take
  always_comb begin
    match = 1'b1;
    dig   = '0;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      dig = (count == CNT_W'(i)) ? key_code : digits[i];
      if (dig != code_ext[DIGIT_W*(CODE_LENGTH-1-i) +: DIGIT_W]) begin
        match = 1'b0;
      end
    end
  end

  assign is_digit  = key_code inside {[KEY_DIGIT_LO:KEY_DIGIT_HI]};
  // only the digit that completes the entry can pass; confirm on a
  // stored entry always finds it short
  assign ok        = is_digit && (count == CNT_LAST) && match;
  assign do_check  = (is_digit && (count == CNT_LAST)) || (key_code == KEY_CONFIRM);
  assign tally_inc = (st.error_tally == ERR_SAT) ? ERR_SAT : st.error_tally + 1'b1;
  assign doubled   = {st.next_wait, 1'b0};
  assign cd_dec    = (st.countdown != '0) ? st.countdown - 1'b1 : st.countdown;

  always_comb begin
    st_next    = st;
    count_next = count;
    push       = 1'b0;
    ev         = EV_IGNORED;
    if (kind == KIND_TICK) begin
      if (st.lock_flag) begin
        st_next.countdown = cd_dec;
        if (cd_dec == '0) begin
          st_next.lock_flag   = 1'b0;
          st_next.error_tally = '0;
          ev                  = EV_RELEASED;
        end else begin
          ev = EV_TICK;
        end
      end
    end else if (!st.lock_flag) begin
      if (do_check && (is_digit ? (count < CNT_FULL) : 1'b1)) begin
        count_next = '0;
        if (ok) begin
          st_next.error_tally = '0;
          ev                  = EV_ACCEPT;
        end else begin
          st_next.error_tally = tally_inc;
          if (tally_inc >= cfg.max_errors) begin
            st_next.lock_flag = 1'b1;
            st_next.countdown = (st.next_wait == '0) ? WAIT_W'(1) : st.next_wait;
            st_next.next_wait = (doubled > {1'b0, cfg.wait_cap}) ? cfg.wait_cap
                                                                 : doubled[WAIT_W-1:0];
            ev                = EV_LOCKED;
          end else begin
            ev = EV_REJECT;
          end
        end
      end else if (is_digit && (count < CNT_FULL)) begin
        push       = 1'b1;
        count_next = count + 1'b1;
        ev         = EV_STORED;
      end else if ((key_code == KEY_DELETE) && (count != '0)) begin
        count_next = count - 1'b1;
        ev         = EV_REMOVED;
      end
    end
  end

endmodule

FILE: rtl/core/kcl_checker.sv
// kcl_checker: port-level assertions for the keypad code lock
// bound to keypad_code_lock_with_lockout_core
// depends on kcl_pkg
`timescale 1ns / 1ps

module kcl_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [kcl_pkg::M_DATA_W-1:0] m_tdata
);
  import kcl_pkg::*;

  result_t res;

  assign res = result_t'(m_tdata[RES_W-1:0]);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // no seconds shown while unlocked
  a_idle_secs: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !res.locked |-> res.seconds_left == '0)
    else $error("seconds left while unlocked");

  // acceptance clears entry and failures and is never locked
  a_accept: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.event_res == EV_ACCEPT |->
      res.failures == '0 && res.digits_held == '0 && !res.locked)
    else $error("accept left state behind");

  // a lockout starts with a nonzero countdown and an empty entry
  a_lock: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.event_res == EV_LOCKED |->
      res.locked && res.seconds_left != '0 && res.digits_held == '0)
    else $error("bad lockout start");

endmodule

bind keypad_code_lock_with_lockout_core kcl_checker u_kcl_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
